[hw/rtl/matrix_inverse_3x3_macros.svh]
// assertion macros for the 3x3 matrix inverse block
// expects aclk and aresetn in the scope of use
`ifndef MATRIX_INVERSE_3X3_MACROS_SVH
`define MATRIX_INVERSE_3X3_MACROS_SVH
`ifndef SYNTHESIS
`define MI3_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("matrix inverse check failed");
`define MI3_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("matrix inverse check failed");
`else
`define MI3_ASSERT_IMP(label, ante, cons)
`define MI3_ASSERT_NXT(label, ante, cons)
`endif
`endif

[hw/rtl/mi3_pkg.sv]
// shared types and constants for the 3x3 matrix inverse block
// no dependencies
package mi3_pkg;
    localparam int DET_W     = 34;
    localparam int INV_W     = 32;
    localparam int RES_FRAC  = 16;
    localparam int NUM_ADJ   = 9;
    localparam int NUM_PROD  = 18;
    localparam int OUT_TW    = ((DET_W + NUM_ADJ * INV_W + 7) / 8) * 8;

    localparam logic [DET_W-1:0] DET_POS_MAX = {1'b0, {(DET_W-1){1'b1}}};
    localparam logic [DET_W-1:0] DET_NEG_MAG = {1'b1, {(DET_W-1){1'b0}}};
    localparam logic [INV_W-1:0] INV_POS_MAX = {1'b0, {(INV_W-1){1'b1}}};
    localparam logic [INV_W-1:0] INV_NEG_MIN = {1'b1, {(INV_W-1){1'b0}}};

    // cofactor product operands, element order a b c d e f g h k
    localparam int unsigned CF_A [NUM_PROD] =
        '{4, 5, 2, 1, 1, 2, 5, 3, 0, 2, 2, 0, 3, 4, 1, 0, 0, 1};
    localparam int unsigned CF_B [NUM_PROD] =
        '{8, 7, 7, 8, 5, 4, 6, 8, 8, 6, 3, 5, 7, 6, 6, 7, 4, 3};

    typedef struct packed {
        logic             valid;
        logic             singular;
        logic [DET_W-1:0] det;
    } side_t;
endpackage

[hw/rtl/mi3_det.sv]
// cofactor and determinant pipeline, four register stages
// depends on mi3_pkg
module mi3_det #(
    parameter int W = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 en,
    input  logic                 v_i,
    input  logic signed [W-1:0]  elem_i [0:8],
    output logic                 v_o,
    output logic signed [2*W:0]  adj_o [0:8],
    output logic signed [3*W+2:0] det_o
);
    import mi3_pkg::*;

    localparam int AW = 2 * W + 1;
    localparam int PW = 3 * W + 1;
    localparam int DW = 3 * W + 3;

    logic [3:0]           v_reg;
    logic signed [2*W-1:0] prod_reg [0:NUM_PROD-1];
    logic signed [2*W-1:0] prod_next [0:NUM_PROD-1];
    logic signed [W-1:0]  abc1_reg [0:2];
    logic signed [W-1:0]  abc2_reg [0:2];
    logic signed [AW-1:0] adj2_reg [0:8];
    logic signed [AW-1:0] adj2_next [0:8];
    logic signed [AW-1:0] adj3_reg [0:8];
    logic signed [AW-1:0] adj4_reg [0:8];
    logic signed [PW-1:0] dp_reg [0:2];
    logic signed [PW-1:0] dp_next [0:2];
    logic signed [DW-1:0] det_reg;
    logic signed [DW-1:0] det_next;

    always_comb begin
        for (int i = 0; i < NUM_PROD; i++) begin
            prod_next[i] = elem_i[CF_A[i]] * elem_i[CF_B[i]];
        end
        for (int j = 0; j < NUM_ADJ; j++) begin
            adj2_next[j] = prod_reg[2*j] - prod_reg[2*j+1];
        end
        dp_next[0] = abc2_reg[0] * adj2_reg[0];
        dp_next[1] = abc2_reg[1] * adj2_reg[3];
        dp_next[2] = abc2_reg[2] * adj2_reg[6];
        det_next   = dp_reg[0] + dp_reg[1] + dp_reg[2];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[2:0], v_i};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg <= prod_next;
            abc1_reg <= elem_i[0:2];
            abc2_reg <= abc1_reg;
            adj2_reg <= adj2_next;
            adj3_reg <= adj2_reg;
            adj4_reg <= adj3_reg;
            dp_reg   <= dp_next;
            det_reg  <= det_next;
        end
    end

    assign v_o   = v_reg[3];
    assign adj_o = adj4_reg;
    assign det_o = det_reg;
endmodule

[hw/rtl/mi3_div_stage.sv]
// one restoring division step for all nine lanes, one register stage
// depends on mi3_pkg
module mi3_div_stage #(
    parameter int XW    = 84,
    parameter int DW    = 51,
    parameter int SHIFT = 31
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       en,
    input  mi3_pkg::side_t             side_i,
    input  logic [DW-1:0]              den_i,
    input  logic [XW-1:0]              rem_i [0:8],
    input  logic [mi3_pkg::INV_W-1:0]  q_i [0:8],
    input  logic [8:0]                 ovf_i,
    input  logic [8:0]                 neg_i,
    output mi3_pkg::side_t             side_o,
    output logic [DW-1:0]              den_o,
    output logic [XW-1:0]              rem_o [0:8],
    output logic [mi3_pkg::INV_W-1:0]  q_o [0:8],
    output logic [8:0]                 ovf_o,
    output logic [8:0]                 neg_o
);
    import mi3_pkg::*;

    side_t            side_reg;
    logic [DW-1:0]    den_reg;
    logic [XW-1:0]    rem_reg [0:8];
    logic [XW-1:0]    rem_next [0:8];
    logic [INV_W-1:0] q_reg [0:8];
    logic [INV_W-1:0] q_next [0:8];
    logic [8:0]       ovf_reg;
    logic [8:0]       neg_reg;

    always_comb begin
        logic [XW-1:0] sub;
        logic [XW:0]   diff;
        sub = XW'(den_i) << SHIFT;
        for (int j = 0; j < NUM_ADJ; j++) begin
            diff = {1'b0, rem_i[j]} - {1'b0, sub};
            if (!diff[XW]) begin
                rem_next[j] = diff[XW-1:0];
                q_next[j]   = q_i[j] | (INV_W'(1) << SHIFT);
            end else begin
                rem_next[j] = rem_i[j];
                q_next[j]   = q_i[j];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            side_reg <= '0;
        end else if (en) begin
            side_reg <= side_i;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            den_reg <= den_i;
            rem_reg <= rem_next;
            q_reg   <= q_next;
            ovf_reg <= ovf_i;
            neg_reg <= neg_i;
        end
    end

    assign side_o = side_reg;
    assign den_o  = den_reg;
    assign rem_o  = rem_reg;
    assign q_o    = q_reg;
    assign ovf_o  = ovf_reg;
    assign neg_o  = neg_reg;
endmodule

[hw/rtl/matrix_inverse_3x3.sv]
// 3x3 matrix inverse by adjugate, top level
// depends on mi3_pkg, mi3_det, mi3_div_stage and matrix_inverse_3x3_macros.svh
// One matrix enters per clock unless the pipeline stops; its result passes through one input
// register, four stages of cofactor and determinant products, two stages of
// sign, magnitude and overflow preparation, one restoring division stage per
// quotient bit (32, all nine entries side by side) and the output register.
// The whole pipeline advances together; it stops only while a result waits at
// the output, and s_axis_tready is low for exactly those cycles.
module matrix_inverse_3x3 #(
    parameter int ELEMENT_WIDTH = 16,
    parameter int ELEMENT_FRAC_BITS = 8,
    localparam int IN_TW = ((9 * ELEMENT_WIDTH + 7) / 8) * 8
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    // m00 m01 m02 m10 m11 m12 m20 m21 m22
    input  logic [IN_TW-1:0]           s_axis_tdata,
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    // determinant r00 r01 r02 r10 r11 r12 r20 r21 r22
    output logic [mi3_pkg::OUT_TW-1:0] m_axis_tdata,
    // singular
    output logic [0:0]                 m_axis_tuser
);
    import mi3_pkg::*;
    `include "matrix_inverse_3x3_macros.svh"

    localparam int W  = ELEMENT_WIDTH;
    localparam int F  = ELEMENT_FRAC_BITS;
    localparam int AW = 2 * W + 1;
    localparam int DW = 3 * W + 3;
    localparam int NW = AW + F + RES_FRAC;
    localparam int XW = ((NW > DW + INV_W) ? NW : DW + INV_W) + 1;
    localparam int CW = (DW > DET_W + 2 * F + 1) ? DW : DET_W + 2 * F + 1;

    logic adv;

    logic                 in_v_reg;
    logic signed [W-1:0]  elem_reg [0:8];

    logic                 det_v;
    logic signed [AW-1:0] adj [0:8];
    logic signed [DW-1:0] det;

    logic                 p5_v_reg;
    logic                 p5_sing_reg;
    logic [DET_W-1:0]     p5_det_reg;
    logic [DW-1:0]        p5_dmag_reg;
    logic [AW-1:0]        p5_amag_reg [0:8];
    logic [8:0]           p5_neg_reg;
    logic [DET_W-1:0]     det_out_next;
    logic [DW-1:0]        dmag_next;
    logic [AW-1:0]        amag_next [0:8];
    logic [8:0]           neg_next;

    side_t                side_s [0:INV_W];
    logic [DW-1:0]        den_s  [0:INV_W];
    logic [XW-1:0]        rem_s  [0:INV_W][0:8];
    logic [INV_W-1:0]     q_s    [0:INV_W][0:8];
    logic [8:0]           ovf_s  [0:INV_W];
    logic [8:0]           neg_s  [0:INV_W];

    side_t                p6_side_reg;
    logic [DW-1:0]        p6_den_reg;
    logic [XW-1:0]        p6_rem_reg [0:8];
    logic [8:0]           p6_ovf_reg;
    logic [8:0]           p6_neg_reg;
    logic [8:0]           ovf_next;
    logic [XW-1:0]        rem_next [0:8];

    logic                 m_valid_reg;
    logic [OUT_TW-1:0]    m_data_reg;
    logic [OUT_TW-1:0]    m_data_next;
    logic                 m_sing_reg;

    assign adv           = !m_valid_reg || m_axis_tready;
    assign s_axis_tready = adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_v_reg <= 1'b0;
        end else if (adv) begin
            in_v_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int j = 0; j < 9; j++) begin
                elem_reg[j] <= s_axis_tdata[j*W +: W];
            end
        end
    end

    mi3_det #(.W(W)) u_det (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (adv),
        .v_i     (in_v_reg),
        .elem_i  (elem_reg),
        .v_o     (det_v),
        .adj_o   (adj),
        .det_o   (det)
    );

    // sign, magnitude and truncated determinant
    always_comb begin
        logic [CW-1:0] dsh;
        logic          dneg;
        dneg      = det[DW-1];
        dmag_next = dneg ? DW'(-det) : DW'(det);
        dsh       = CW'(dmag_next) >> (2 * F);
        if (dneg) begin
            det_out_next = (dsh > CW'(DET_NEG_MAG)) ? DET_NEG_MAG : -dsh[DET_W-1:0];
        end else begin
            det_out_next = (dsh > CW'(DET_POS_MAX)) ? DET_POS_MAX : dsh[DET_W-1:0];
        end
        for (int j = 0; j < NUM_ADJ; j++) begin
            amag_next[j] = adj[j][AW-1] ? AW'(-adj[j]) : AW'(adj[j]);
            neg_next[j]  = adj[j][AW-1] ^ dneg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p5_v_reg <= 1'b0;
        end else if (adv) begin
            p5_v_reg <= det_v;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            p5_sing_reg <= (det == '0);
            p5_det_reg  <= det_out_next;
            p5_dmag_reg <= dmag_next;
            p5_amag_reg <= amag_next;
            p5_neg_reg  <= neg_next;
        end
    end

    // scaled numerators and quotient overflow
    always_comb begin
        logic [XW-1:0] lim;
        lim = XW'(p5_dmag_reg) << INV_W;
        for (int j = 0; j < NUM_ADJ; j++) begin
            rem_next[j] = XW'(p5_amag_reg[j]) << (F + RES_FRAC);
            ovf_next[j] = rem_next[j] >= lim;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p6_side_reg <= '0;
        end else if (adv) begin
            p6_side_reg <= '{valid: p5_v_reg, singular: p5_sing_reg, det: p5_det_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            p6_den_reg <= p5_dmag_reg;
            p6_rem_reg <= rem_next;
            p6_ovf_reg <= ovf_next;
            p6_neg_reg <= p5_neg_reg;
        end
    end

    assign side_s[0] = p6_side_reg;
    assign den_s[0]  = p6_den_reg;
    assign rem_s[0]  = p6_rem_reg;
    assign ovf_s[0]  = p6_ovf_reg;
    assign neg_s[0]  = p6_neg_reg;
    always_comb begin
        for (int j = 0; j < NUM_ADJ; j++) begin
            q_s[0][j] = '0;
        end
    end

    for (genvar s = 0; s < INV_W; s++) begin : g_div
        mi3_div_stage #(.XW(XW), .DW(DW), .SHIFT(INV_W - 1 - s)) u_stage (
            .aclk    (aclk),
            .aresetn (aresetn),
            .en      (adv),
            .side_i  (side_s[s]),
            .den_i   (den_s[s]),
            .rem_i   (rem_s[s]),
            .q_i     (q_s[s]),
            .ovf_i   (ovf_s[s]),
            .neg_i   (neg_s[s]),
            .side_o  (side_s[s+1]),
            .den_o   (den_s[s+1]),
            .rem_o   (rem_s[s+1]),
            .q_o     (q_s[s+1]),
            .ovf_o   (ovf_s[s+1]),
            .neg_o   (neg_s[s+1])
        );
    end

    // saturate and pack
    always_comb begin
        logic [INV_W-1:0] q;
        logic [INV_W-1:0] r;
        m_data_next = '0;
        m_data_next[DET_W-1:0] = side_s[INV_W].det;
        for (int j = 0; j < NUM_ADJ; j++) begin
            q = q_s[INV_W][j];
            if (side_s[INV_W].singular) begin
                r = '0;
            end else if (neg_s[INV_W][j]) begin
                r = (ovf_s[INV_W][j] || (q[INV_W-1] && |q[INV_W-2:0])) ? INV_NEG_MIN : -q;
            end else begin
                r = (ovf_s[INV_W][j] || q[INV_W-1]) ? INV_POS_MAX : q;
            end
            m_data_next[DET_W + j*INV_W +: INV_W] = r;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= side_s[INV_W].valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_data_reg <= m_data_next;
            m_sing_reg <= side_s[INV_W].singular;
        end
    end

    assign m_axis_tvalid   = m_valid_reg;
    assign m_axis_tdata    = m_data_reg;
    assign m_axis_tuser[0] = m_sing_reg;

    `MI3_ASSERT_IMP(a_sing_det_zero, m_axis_tvalid && m_axis_tuser[0], m_axis_tdata[DET_W-1:0] == '0)
    `MI3_ASSERT_IMP(a_sing_inv_zero, m_axis_tvalid && m_axis_tuser[0], m_axis_tdata[OUT_TW-1:DET_W] == '0)
    `MI3_ASSERT_NXT(a_out_follows, adv && side_s[INV_W].valid, m_axis_tvalid)
endmodule

[dv/testbench.sv]
// testbench for the 3x3 matrix inverse block: directed table then random matrices,
// every result checked against an adjugate predictor in order
// depends on mi3_pkg and matrix_inverse_3x3
module testbench;
    import mi3_pkg::*;

    localparam int EW = 16;
    localparam int EF = 8;
    localparam int IN_TW = ((9 * EW + 7) / 8) * 8;
    localparam int N_RANDOM = 930;
    localparam int WATCHDOG = 20000;
    localparam int DRAIN = 60;

    typedef struct packed {
        logic [INV_W-1:0] r22, r21, r20, r12, r11, r10, r02, r01, r00;
        logic [DET_W-1:0] det;
        logic             singular;
    } inverse_t;

    typedef struct {
        logic [EW-1:0] m [9];
        bit            typed;
        inverse_t      want;
    } matrix_row_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [IN_TW-1:0] s_axis_tdata = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [OUT_TW-1:0] m_axis_tdata;
    logic [0:0] m_axis_tuser;

    matrix_row_t table_rows [$];
    inverse_t pending_inverses [$];
    int errors = 0;
    int idle_cycles = 0;
    bit stim_done = 0;
    bit hold_off = 0;

    always #2 aclk = ~aclk;

    matrix_inverse_3x3 dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
    );

    function automatic logic [INV_W-1:0] sat_quotient(logic signed [127:0] num,
                                                      logic signed [127:0] den);
        logic [127:0] mag_n;
        logic [127:0] mag_d;
        logic [127:0] q;
        bit neg;
        neg = (num < 0) != (den < 0);
        mag_n = (num < 0) ? -num : num;
        mag_d = (den < 0) ? -den : den;
        q = (mag_n << (EF + RES_FRAC)) / mag_d;
        if (neg) begin
            if (q > 128'h8000_0000) return INV_NEG_MIN;
            return -q[INV_W-1:0];
        end
        if (q > 128'h7fff_ffff) return INV_POS_MAX;
        return q[INV_W-1:0];
    endfunction

    function automatic inverse_t invert_matrix(logic [EW-1:0] m [9]);
        logic signed [127:0] e [9];
        logic signed [127:0] adj [9];
        logic signed [127:0] det;
        logic [127:0] dmag;
        inverse_t r;
        logic [INV_W-1:0] q [9];
        for (int i = 0; i < 9; i++) e[i] = signed'(m[i]);
        adj[0] = e[4]*e[8] - e[5]*e[7];
        adj[1] = e[2]*e[7] - e[1]*e[8];
        adj[2] = e[1]*e[5] - e[2]*e[4];
        adj[3] = e[5]*e[6] - e[3]*e[8];
        adj[4] = e[0]*e[8] - e[2]*e[6];
        adj[5] = e[2]*e[3] - e[0]*e[5];
        adj[6] = e[3]*e[7] - e[4]*e[6];
        adj[7] = e[1]*e[6] - e[0]*e[7];
        adj[8] = e[0]*e[4] - e[1]*e[3];
        det = e[0]*adj[0] + e[1]*adj[3] + e[2]*adj[6];
        r = '0;
        if (det == 0) begin
            r.singular = 1'b1;
            return r;
        end
        dmag = (det < 0) ? -det : det;
        dmag = dmag >> (2 * EF);
        if (det < 0) r.det = (dmag > {DET_NEG_MAG}) ? DET_NEG_MAG : -dmag[DET_W-1:0];
        else r.det = (dmag > {DET_POS_MAX}) ? DET_POS_MAX : dmag[DET_W-1:0];
        for (int i = 0; i < 9; i++) q[i] = sat_quotient(adj[i], det);
        {r.r22, r.r21, r.r20, r.r12, r.r11, r.r10, r.r02, r.r01, r.r00} =
            {q[8], q[7], q[6], q[5], q[4], q[3], q[2], q[1], q[0]};
        return r;
    endfunction

    task automatic add_row(logic [EW-1:0] m0, m1, m2, m3, m4, m5, m6, m7, m8,
                           bit typed = 0, inverse_t want = '0);
        matrix_row_t row;
        row.m = '{m0, m1, m2, m3, m4, m5, m6, m7, m8};
        row.typed = typed;
        row.want = want;
        table_rows.push_back(row);
    endtask

    task automatic send_matrix(matrix_row_t row);
        logic [IN_TW-1:0] packed_m;
        inverse_t want;
        packed_m = '0;
        for (int i = 0; i < 9; i++) packed_m[i*EW +: EW] = row.m[i];
        want = invert_matrix(row.m);
        if (row.typed && want != row.want) begin
            $error("predictor disagrees with table row");
            errors++;
        end
        s_axis_tdata <= packed_m;
        s_axis_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_axis_tready);
        pending_inverses.push_back(row.typed ? row.want : want);
    endtask

    function automatic logic [EW-1:0] random_element();
        case ($urandom_range(0, 5))
            0: return $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
            1: return EW'($urandom_range(0, 8) - 4);
            2: return EW'(16'h0100 * $urandom_range(0, 4) - 16'h0200);
            default: return EW'($urandom);
        endcase
    endfunction

    task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            $error("%s expected %0h got %0h", name, want, got);
            errors++;
        end
    endtask

    // result side: check every accepted item against the oldest expectation
    always @(posedge aclk) begin
        inverse_t want;
        inverse_t got;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            got.singular = m_axis_tuser[0];
            got.det = m_axis_tdata[0 +: DET_W];
            {got.r22, got.r21, got.r20, got.r12, got.r11, got.r10, got.r02, got.r01,
             got.r00} = m_axis_tdata[DET_W +: NUM_ADJ*INV_W];
            if (pending_inverses.size() == 0) begin
                $error("result with no matrix outstanding");
                errors++;
            end else begin
                want = pending_inverses.pop_front();
                check_field("singular", want.singular, got.singular);
                check_field("determinant", want.det, got.det);
                check_field("r00", want.r00, got.r00);
                check_field("r01", want.r01, got.r01);
                check_field("r02", want.r02, got.r02);
                check_field("r10", want.r10, got.r10);
                check_field("r11", want.r11, got.r11);
                check_field("r12", want.r12, got.r12);
                check_field("r20", want.r20, got.r20);
                check_field("r21", want.r21, got.r21);
                check_field("r22", want.r22, got.r22);
            end
        end
    end

    // receiver stall pattern, with one long hold-off
    always @(posedge aclk) begin
        if (hold_off) m_axis_tready <= 1'b0;
        else if (stim_done) m_axis_tready <= ($urandom_range(0, 3) != 0);
        else m_axis_tready <= ($urandom_range(0, 9) < 7);
    end

    initial begin
        @(posedge aclk);
        wait (table_rows.size() == 0 && aresetn);
        repeat (200) @(posedge aclk);
        hold_off <= 1'b1;
        repeat (150) @(posedge aclk);
        hold_off <= 1'b0;
    end

    always @(posedge aclk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        matrix_row_t row;
        inverse_t want;
        int burst;
        // identity: unit determinant, unit inverse
        want = '0;
        want.det = 34'h100;
        want.r00 = 32'h10000; want.r11 = 32'h10000; want.r22 = 32'h10000;
        add_row(16'h100, 0, 0, 0, 16'h100, 0, 0, 0, 16'h100, 1, want);
        // all zero and repeated rows are singular
        want = '0;
        want.singular = 1'b1;
        add_row(0, 0, 0, 0, 0, 0, 0, 0, 0, 1, want);
        add_row(16'h7fff, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000, 16'h7fff,
                1, 2, 3, 1, want);
        add_row(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000,
                16'h8000, 16'h8000, 16'h8000, 1, want);
        // tiny determinant: nonzero but truncates to zero
        add_row(1, 0, 0, 0, 1, 0, 0, 0, 1);
        add_row(16'hffff, 0, 0, 0, 1, 0, 0, 0, 1);
        // extremes of the diagonal and full scale
        add_row(16'h7fff, 0, 0, 0, 16'h7fff, 0, 0, 0, 16'h7fff);
        add_row(16'h8000, 0, 0, 0, 16'h8000, 0, 0, 0, 16'h8000);
        add_row(16'h8000, 16'h7fff, 16'h7fff, 16'h7fff, 16'h8000, 16'h7fff,
                16'h7fff, 16'h7fff, 16'h8000);
        add_row(16'h7fff, 16'h8000, 16'h8000, 16'h8000, 16'h7fff, 16'h8000,
                16'h8000, 16'h8000, 16'h7fff);
        add_row(16'hffff, 16'hffff, 16'h0, 16'h0, 16'hffff, 16'hffff, 16'hffff, 0, 16'hffff);
        add_row(16'h200, 16'h100, 0, 16'h100, 16'h200, 16'h100, 0, 16'h100, 16'h200);
        add_row(0, 16'h100, 0, 0, 0, 16'h100, 16'h100, 0, 0);
        add_row(16'h5555, 16'haaaa, 16'h1234, 16'hedcb, 16'h0f0f, 16'hf0f0,
                16'h3c3c, 16'hc3c3, 16'h0001);

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        while (table_rows.size() > 0) begin
            row = table_rows.pop_front();
            send_matrix(row);
        end
        s_axis_tvalid <= 1'b0;
        for (int n = 0; n < N_RANDOM; ) begin
            burst = $urandom_range(1, 40);
            for (int b = 0; b < burst && n < N_RANDOM; b++, n++) begin
                for (int i = 0; i < 9; i++) row.m[i] = random_element();
                row.typed = 0;
                // some rank-deficient matrices: copy a row
                if ($urandom_range(0, 9) == 0)
                    for (int i = 0; i < 3; i++) row.m[6+i] = row.m[i];
                send_matrix(row);
            end
            if ($urandom_range(0, 2) != 0) begin
                s_axis_tvalid <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge aclk);
            end
        end
        s_axis_tvalid <= 1'b0;
        stim_done = 1;
        while (pending_inverses.size() > 0) @(posedge aclk);
        repeat (DRAIN) @(posedge aclk);
        if (errors == 0) $display("PASS");
        else $display("FAIL");
        $finish;
    end
endmodule

[files.f]
+incdir+hw/rtl
hw/rtl/mi3_pkg.sv
hw/rtl/mi3_det.sv
hw/rtl/mi3_div_stage.sv
hw/rtl/matrix_inverse_3x3.sv
dv/testbench.sv
